>>> src/tss_pkg.sv
// Shared types and constants of the thread scheduler.
package tss_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int KIND_W          = 3;
  localparam int ID_W            = 4;
  localparam int TIME_W          = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 3'd0,
    KIND_RUN    = 3'd1,
    KIND_YIELD  = 3'd2,
    KIND_SLEEP  = 3'd3,
    KIND_FINISH = 3'd4,
    KIND_TICK   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_INS_RD,
    ST_INS_CMP,
    ST_WAKE_RD,
    ST_WAKE_CMP,
    ST_PICK_RD,
    ST_PICK,
    ST_RESP
  } state_t;

endpackage

>>> src/tss_in_if.sv
// Request channel of the thread scheduler.
interface tss_in_if;
  logic                      valid;
  logic                      ready;
  logic [tss_pkg::KIND_W-1:0] kind;
  logic [tss_pkg::ID_W-1:0]   thread_id;
  logic [tss_pkg::TIME_W-1:0] delay;
  logic [tss_pkg::TIME_W-1:0] now;

  modport source (output valid, kind, thread_id, delay, now, input ready);
  modport sink   (input valid, kind, thread_id, delay, now, output ready);
endinterface

>>> src/tss_out_if.sv
// Result channel of the thread scheduler.
interface tss_out_if;
  logic                     valid;
  logic                     ready;
  logic [tss_pkg::ID_W-1:0] running_thread;
  logic                     switched;
  logic                     waiting;
  logic                     status;

  modport source (output valid, running_thread, switched, waiting, status, input ready);
  modport sink   (input valid, running_thread, switched, waiting, status, output ready);
endinterface

>>> src/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/thread_scheduler_with_sleep_queue.sv
// Cooperative thread scheduler: a circular ready queue and a circular sleep list sorted
// by wake time, each held in a RAM, worked by one sequencer around a shared 32-bit
// comparator. One request is taken at a time and gives one result. A create pushes the
// thread onto the ready queue; a tick only returns the current state. Run, yield, sleep
// and finish wake the sleepers that are due and pick the next thread; yield first pushes
// the current thread, and sleep first inserts it into the sleep list, moving later entries
// to make room. While waiting is reported, every request rescans the sleepers.
module thread_scheduler_with_sleep_queue #(
  parameter int MAX_THREADS = tss_pkg::MAX_THREADS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tss_in_if.sink    in_req,
  tss_out_if.source out_rsp
);

  localparam int AW   = $clog2(MAX_THREADS);
  localparam int CW   = $clog2(MAX_THREADS + 1);
  localparam int SW   = CW + 1;
  localparam int ID_W = tss_pkg::ID_W;
  localparam int TW   = tss_pkg::TIME_W;
  localparam int SLW  = ID_W + TW;

  localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_THREADS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_THREADS);
  localparam logic [SW-1:0] DEPTH_SUM = SW'(MAX_THREADS);

  tss_pkg::state_t state_r, state_nxt;

  logic [tss_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [ID_W-1:0]            tid_r, tid_nxt;
  logic [TW-1:0]              wake_r, wake_nxt;
  logic [TW-1:0]              now_r, now_nxt;

  logic [AW-1:0] rq_head_r, rq_head_nxt;
  logic [CW-1:0] rq_cnt_r, rq_cnt_nxt;
  logic [AW-1:0] sl_head_r, sl_head_nxt;
  logic [CW-1:0] sl_cnt_r, sl_cnt_nxt;
  logic [ID_W-1:0] cur_r, cur_nxt;
  logic          blocked_r, blocked_nxt;
  logic          sw_r, sw_nxt;
  logic          status_r, status_nxt;

  logic [AW-1:0] ins_p_r, ins_p_nxt;
  logic [CW-1:0] ins_k_r, ins_k_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] out_thread_r, out_thread_nxt;
  logic            out_sw_r, out_sw_nxt;
  logic            out_wait_r, out_wait_nxt;
  logic            out_status_r, out_status_nxt;

  logic            rq_we;
  logic [AW-1:0]   rq_waddr, rq_raddr;
  logic [ID_W-1:0] rq_wdata, rq_rdata;
  logic            sl_we;
  logic [AW-1:0]   sl_waddr, sl_raddr;
  logic [SLW-1:0]  sl_wdata, sl_rdata;

  logic [SW-1:0] rq_sum, sl_sum;
  logic [AW-1:0] rq_tail, sl_tail, ins_p_prev, rq_head_inc, sl_head_inc;
  logic          rq_full, sl_full, accept, rsp_free;
  logic [TW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;
  logic [TW-1:0] sl_rd_wake;
  logic [ID_W-1:0] sl_rd_id;

  tss_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_ready_ram (
    .clk(clk), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
    .raddr(rq_raddr), .rdata(rq_rdata)
  );

  tss_ram #(.WIDTH(SLW), .DEPTH(MAX_THREADS)) u_sleep_ram (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(sl_raddr), .rdata(sl_rdata)
  );

  assign rq_sum      = SW'(rq_head_r) + SW'(rq_cnt_r);
  assign rq_tail     = (rq_sum >= DEPTH_SUM) ? AW'(rq_sum - DEPTH_SUM) : AW'(rq_sum);
  assign sl_sum      = SW'(sl_head_r) + SW'(sl_cnt_r);
  assign sl_tail     = (sl_sum >= DEPTH_SUM) ? AW'(sl_sum - DEPTH_SUM) : AW'(sl_sum);
  assign ins_p_prev  = (ins_p_r == '0) ? LAST_IDX : ins_p_r - AW'(1);
  assign rq_head_inc = (rq_head_r == LAST_IDX) ? '0 : rq_head_r + AW'(1);
  assign sl_head_inc = (sl_head_r == LAST_IDX) ? '0 : sl_head_r + AW'(1);
  assign rq_full     = (rq_cnt_r == FULL_CNT);
  assign sl_full     = (sl_cnt_r == FULL_CNT);
  assign sl_rd_wake  = sl_rdata[TW-1:0];
  assign sl_rd_id    = sl_rdata[SLW-1:TW];

  assign in_req.ready = (state_r == tss_pkg::ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign rsp_free     = !out_valid_r || out_rsp.ready;

  // shared comparator: insert tests entry < new wake, wake scan tests now < entry
  assign cmp_a  = (state_r == tss_pkg::ST_INS_CMP) ? sl_rd_wake : now_r;
  assign cmp_b  = (state_r == tss_pkg::ST_INS_CMP) ? wake_r : sl_rd_wake;
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tss_pkg::ST_IDLE: begin
        if (accept) begin
          if (blocked_r) begin
            state_nxt = tss_pkg::ST_WAKE_RD;
          end else begin
            unique case (in_req.kind) inside
              tss_pkg::KIND_CREATE, tss_pkg::KIND_YIELD: state_nxt = tss_pkg::ST_PUSH;
              tss_pkg::KIND_RUN, tss_pkg::KIND_FINISH:   state_nxt = tss_pkg::ST_WAKE_RD;
              tss_pkg::KIND_SLEEP:
                state_nxt = sl_full ? tss_pkg::ST_WAKE_RD : tss_pkg::ST_INS_RD;
              default:                                   state_nxt = tss_pkg::ST_RESP;
            endcase
          end
        end
      end
      tss_pkg::ST_PUSH:
        state_nxt = (kind_r == tss_pkg::KIND_CREATE) ? tss_pkg::ST_RESP : tss_pkg::ST_WAKE_RD;
      tss_pkg::ST_INS_RD:
        state_nxt = (ins_k_r == '0) ? tss_pkg::ST_WAKE_RD : tss_pkg::ST_INS_CMP;
      tss_pkg::ST_INS_CMP:
        state_nxt = cmp_lt ? tss_pkg::ST_WAKE_RD : tss_pkg::ST_INS_RD;
      tss_pkg::ST_WAKE_RD:
        state_nxt = (sl_cnt_r == '0 || rq_full) ? tss_pkg::ST_PICK_RD : tss_pkg::ST_WAKE_CMP;
      tss_pkg::ST_WAKE_CMP:
        state_nxt = cmp_lt ? tss_pkg::ST_PICK_RD : tss_pkg::ST_WAKE_RD;
      tss_pkg::ST_PICK_RD:
        state_nxt = (rq_cnt_r == '0) ? tss_pkg::ST_RESP : tss_pkg::ST_PICK;
      tss_pkg::ST_PICK:
        state_nxt = tss_pkg::ST_RESP;
      tss_pkg::ST_RESP:
        state_nxt = rsp_free ? tss_pkg::ST_IDLE : tss_pkg::ST_RESP;
      default:
        state_nxt = tss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt       = kind_r;
    tid_nxt        = tid_r;
    wake_nxt       = wake_r;
    now_nxt        = now_r;
    rq_head_nxt    = rq_head_r;
    rq_cnt_nxt     = rq_cnt_r;
    sl_head_nxt    = sl_head_r;
    sl_cnt_nxt     = sl_cnt_r;
    cur_nxt        = cur_r;
    blocked_nxt    = blocked_r;
    sw_nxt         = sw_r;
    status_nxt     = status_r;
    ins_p_nxt      = ins_p_r;
    ins_k_nxt      = ins_k_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_thread_nxt = out_thread_r;
    out_sw_nxt     = out_sw_r;
    out_wait_nxt   = out_wait_r;
    out_status_nxt = out_status_r;
    rq_we          = 1'b0;
    rq_waddr       = rq_tail;
    rq_wdata       = cur_r;
    rq_raddr       = rq_head_r;
    sl_we          = 1'b0;
    sl_waddr       = ins_p_r;
    sl_wdata       = {cur_r, wake_r};
    sl_raddr       = ins_p_prev;

    unique case (state_r)
      tss_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_req.kind;
          tid_nxt    = in_req.thread_id;
          wake_nxt   = in_req.now + in_req.delay;
          now_nxt    = in_req.now;
          sw_nxt     = 1'b0;
          status_nxt = 1'b0;
          ins_p_nxt  = sl_tail;
          ins_k_nxt  = sl_cnt_r;
          if (!blocked_r && in_req.kind == tss_pkg::KIND_RUN) begin
            cur_nxt = '0;
          end
        end
      end
      tss_pkg::ST_PUSH: begin
        if (kind_r == tss_pkg::KIND_CREATE) begin
          rq_wdata = tid_r;
        end
        if (rq_full) begin
          status_nxt = (kind_r == tss_pkg::KIND_CREATE);
        end else begin
          rq_we      = 1'b1;
          rq_cnt_nxt = rq_cnt_r + CW'(1);
        end
      end
      tss_pkg::ST_INS_RD: begin
        if (ins_k_r == '0) begin
          sl_we      = 1'b1;
          sl_cnt_nxt = sl_cnt_r + CW'(1);
        end
      end
      tss_pkg::ST_INS_CMP: begin
        sl_we = 1'b1;
        if (cmp_lt) begin
          sl_cnt_nxt = sl_cnt_r + CW'(1);
        end else begin
          sl_wdata  = sl_rdata;
          ins_p_nxt = ins_p_prev;
          ins_k_nxt = ins_k_r - CW'(1);
        end
      end
      tss_pkg::ST_WAKE_RD: begin
        sl_raddr = sl_head_r;
      end
      tss_pkg::ST_WAKE_CMP: begin
        rq_wdata = sl_rd_id;
        if (!cmp_lt) begin
          rq_we       = 1'b1;
          rq_cnt_nxt  = rq_cnt_r + CW'(1);
          sl_head_nxt = sl_head_inc;
          sl_cnt_nxt  = sl_cnt_r - CW'(1);
        end
      end
      tss_pkg::ST_PICK_RD: begin
        if (rq_cnt_r == '0) begin
          if (sl_cnt_r != '0) begin
            blocked_nxt = 1'b1;
            sw_nxt      = 1'b0;
          end else begin
            blocked_nxt = 1'b0;
            sw_nxt      = (cur_r != '0);
            cur_nxt     = '0;
          end
        end
      end
      tss_pkg::ST_PICK: begin
        blocked_nxt = 1'b0;
        sw_nxt      = (rq_rdata != cur_r);
        cur_nxt     = rq_rdata;
        rq_head_nxt = rq_head_inc;
        rq_cnt_nxt  = rq_cnt_r - CW'(1);
      end
      tss_pkg::ST_RESP: begin
        if (rsp_free) begin
          out_valid_nxt  = 1'b1;
          out_thread_nxt = cur_r;
          out_sw_nxt     = sw_r;
          out_wait_nxt   = blocked_r;
          out_status_nxt = status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tss_pkg::ST_IDLE;
      rq_head_r   <= '0;
      rq_cnt_r    <= '0;
      sl_head_r   <= '0;
      sl_cnt_r    <= '0;
      cur_r       <= '0;
      blocked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rq_head_r   <= rq_head_nxt;
      rq_cnt_r    <= rq_cnt_nxt;
      sl_head_r   <= sl_head_nxt;
      sl_cnt_r    <= sl_cnt_nxt;
      cur_r       <= cur_nxt;
      blocked_r   <= blocked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tid_r        <= tid_nxt;
    wake_r       <= wake_nxt;
    now_r        <= now_nxt;
    sw_r         <= sw_nxt;
    status_r     <= status_nxt;
    ins_p_r      <= ins_p_nxt;
    ins_k_r      <= ins_k_nxt;
    out_thread_r <= out_thread_nxt;
    out_sw_r     <= out_sw_nxt;
    out_wait_r   <= out_wait_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.running_thread = out_thread_r;
  assign out_rsp.switched       = out_sw_r;
  assign out_rsp.waiting        = out_wait_r;
  assign out_rsp.status         = out_status_r;

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (rq_cnt_r <= FULL_CNT) && (sl_cnt_r <= FULL_CNT))
    else $error("queue count beyond depth");

  a_blocked_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tss_pkg::ST_IDLE && blocked_r) |-> (rq_cnt_r == '0 && sl_cnt_r != '0))
    else $error("blocked with runnable thread or no sleeper");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("second request taken while busy");

  a_no_switch_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_sw_r && out_wait_r))
    else $error("switch reported while waiting");

endmodule
